FILE: src/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define CSQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define CSQ_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define CSQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define CSQ_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

FILE: src/csq_pkg.sv
// constants, mode codes and scale helper functions for the pitch quantizer
// no dependencies; used by chained_scale_pitch_quantizer
package csq_pkg;

    localparam int NUM_FIELDS = 5;   // harmonic fields in the chain, 1..8
    localparam int REG_FIELDS = 5;   // fields that own register bits
    localparam int PITCH_W    = 7;
    localparam int CLASS_W    = 4;
    localparam int FIELD_W    = 3;
    localparam int ROOT_W     = 4;
    localparam int MODE_W     = 5;
    localparam int ROOTS_W    = 20;
    localparam int MODES_W    = 25;
    localparam int CFG_W      = 25;
    localparam int RES_W      = NUM_FIELDS * PITCH_W;

    localparam logic CFG_ROOTS = 1'b0;
    localparam logic CFG_MODES = 1'b1;

    localparam logic [FIELD_W-1:0] LAST_FIELD = FIELD_W'(NUM_FIELDS - 1);
    localparam logic [ROOT_W-1:0]  ROOT_MAX   = 4'd11;

    localparam logic [MODE_W-1:0] MODE_MAJOR      = 5'd0;
    localparam logic [MODE_W-1:0] MODE_MINOR      = 5'd1;
    localparam logic [MODE_W-1:0] MODE_HARM_MINOR = 5'd2;
    localparam logic [MODE_W-1:0] MODE_DORIAN     = 5'd3;
    localparam logic [MODE_W-1:0] MODE_PHRYGIAN   = 5'd4;
    localparam logic [MODE_W-1:0] MODE_LYDIAN     = 5'd5;
    localparam logic [MODE_W-1:0] MODE_MIXOLYDIAN = 5'd6;
    localparam logic [MODE_W-1:0] MODE_LOCRIAN    = 5'd7;
    localparam logic [MODE_W-1:0] MODE_MAJ7       = 5'd8;
    localparam logic [MODE_W-1:0] MODE_DOM7       = 5'd9;
    localparam logic [MODE_W-1:0] MODE_MAJ6       = 5'd10;
    localparam logic [MODE_W-1:0] MODE_MIN6       = 5'd11;
    localparam logic [MODE_W-1:0] MODE_SIX_FOUR   = 5'd12;
    localparam logic [MODE_W-1:0] MODE_MIN_SIX_FOUR = 5'd13;
    localparam logic [MODE_W-1:0] MODE_SIX_FIVE   = 5'd14;
    localparam logic [MODE_W-1:0] MODE_MIN_SIX_FIVE = 5'd15;
    localparam logic [MODE_W-1:0] MODE_FIVE_FOUR  = 5'd16;
    localparam logic [MODE_W-1:0] MODE_FOUR_TWO   = 5'd17;

    // pitch classes of each mode on root c, bit n = class n
    function automatic logic [11:0] mode_mask(input logic [MODE_W-1:0] mode);
        logic [11:0] m;
        unique case (mode)
            MODE_MAJOR:        m = 12'hAB5;
            MODE_MINOR:        m = 12'h5AD;
            MODE_HARM_MINOR:   m = 12'h9AD;
            MODE_DORIAN:       m = 12'h6AD;
            MODE_PHRYGIAN:     m = 12'h5AB;
            MODE_LYDIAN:       m = 12'hAD5;
            MODE_MIXOLYDIAN:   m = 12'h6B5;
            MODE_LOCRIAN:      m = 12'h56B;
            MODE_MAJ7:         m = 12'h891;
            MODE_DOM7:         m = 12'h491;
            MODE_MAJ6:         m = 12'h211;
            MODE_MIN6:         m = 12'h209;
            MODE_SIX_FOUR:     m = 12'h221;
            MODE_MIN_SIX_FOUR: m = 12'h121;
            MODE_SIX_FIVE:     m = 12'h149;
            MODE_MIN_SIX_FIVE: m = 12'h291;
            MODE_FIVE_FOUR:    m = 12'h0A1;
            MODE_FOUR_TWO:     m = 12'h025;
            default:           m = 12'hAB5;   // unused codes read as major
        endcase
        return m;
    endfunction

    // rotate a class mask up by r classes, r below 12
    function automatic logic [11:0] rotl12(input logic [11:0] m, input logic [CLASS_W-1:0] r);
        logic [23:0] t;
        t = {m, m} << r;
        return t[23:12];
    endfunction

    // rotate a class mask down by r classes, r below 12
    function automatic logic [11:0] rotr12(input logic [11:0] m, input logic [CLASS_W-1:0] r);
        logic [23:0] t;
        t = {m, m} >> r;
        return t[11:0];
    endfunction

    // position of the lowest set bit
    function automatic logic [CLASS_W-1:0] first_set12(input logic [11:0] m);
        logic [CLASS_W-1:0] d;
        d = '0;
        for (int k = 11; k >= 0; k--) begin
            if (m[k]) begin
                d = CLASS_W'(k);
            end
        end
        return d;
    endfunction

    // pitch class of a note number: reciprocal multiply, exact below 128
    function automatic logic [CLASS_W-1:0] mod12(input logic [PITCH_W-1:0] p);
        logic [12:0] prod;
        logic [3:0]  q;
        logic [7:0]  rem;
        prod = {6'd0, p} * 13'd43;
        q    = prod[12:9];
        rem  = {1'b0, p} - ({1'b0, q, 3'b000} + {2'b00, q, 2'b00});
        return rem[CLASS_W-1:0];
    endfunction

    // scale of one field as a 12-bit class mask
    function automatic logic [11:0] class_mask(input logic [ROOT_W-1:0] root,
                                               input logic [MODE_W-1:0] mode);
        logic [ROOT_W-1:0] r;
        r = (root > ROOT_MAX) ? ROOT_MAX : root;
        return rotl12(mode_mask(mode), r);
    endfunction

endpackage

FILE: src/chained_scale_pitch_quantizer.sv
// top level of the chained scale pitch quantizer: field pipeline and result serializer
// depends on csq_pkg and assert_macros.svh
//
// A note number request enters and runs through a chain of NUM_FIELDS harmonic
// fields, one pipeline stage per field. Each field raises the pitch it gets to
// the nearest pitch of its scale at or above it and hands that on; when no such
// pitch lies at or below 127 the result is flagged not found and the pitch goes
// on unchanged. Every note yields NUM_FIELDS results in field order, the last one
// marked. A new note can enter in every cycle while the pipeline has room, but
// results leave one per cycle through the serializer while i_stall is low, so
// a note leaves the last field stage only once every result of the note before
// it is taken. A note is registered in stage 0, passes field stages 1 to N and
// then the serializer buffer, which shows its first result. Configuration writes
// take effect at the write edge; the scale masks are rebuilt in the same cycle.
module chained_scale_pitch_quantizer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [csq_pkg::CFG_W-1:0]     i_cfg_data,
    // note request channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [csq_pkg::PITCH_W-1:0]   i_pitch_in,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [csq_pkg::PITCH_W-1:0]   o_pitch_out,
    output logic [csq_pkg::FIELD_W-1:0]   o_field_index,
    output logic                          o_found,
    output logic                          o_last_result
);

    localparam int N = csq_pkg::NUM_FIELDS;

    // configuration registers and derived scale masks
    logic [csq_pkg::ROOTS_W-1:0] r_roots;
    logic [csq_pkg::MODES_W-1:0] r_modes;
    logic [csq_pkg::ROOTS_W-1:0] n_roots;
    logic [csq_pkg::MODES_W-1:0] n_modes;
    logic [11:0]                 r_mask [N];
    logic [11:0]                 n_mask [N];

    // pipeline: stage 0 holds the incoming note, stage s holds it after field s-1
    logic [N:0]                      r_vld;
    logic [N:0]                      w_load;
    logic [N:0]                      w_go;
    logic [csq_pkg::PITCH_W-1:0]     r_pitch [N+1];
    logic [csq_pkg::CLASS_W-1:0]     r_cls   [N+1];
    logic [csq_pkg::RES_W-1:0]       r_rp    [N+1];
    logic [N-1:0]                    r_rf    [N+1];

    // result serializer
    logic                            r_sv;
    logic [csq_pkg::FIELD_W-1:0]     r_idx;
    logic [csq_pkg::RES_W-1:0]       r_bp;
    logic [N-1:0]                    r_bf;
    logic                            w_out_acc;
    logic                            w_out_last;
    logic                            w_buf_take;

    // ---------------------------------------------------------------- config
    always_comb begin
        n_roots = r_roots;
        n_modes = r_modes;
        if (i_cfg_we && i_cfg_idx == csq_pkg::CFG_ROOTS) begin
            n_roots = i_cfg_data[csq_pkg::ROOTS_W-1:0];
        end
        if (i_cfg_we && i_cfg_idx == csq_pkg::CFG_MODES) begin
            n_modes = i_cfg_data[csq_pkg::MODES_W-1:0];
        end
    end

    // fields past the register bits read root c, major
    for (genvar f = 0; f < N; f++) begin : g_mask
        if (f < csq_pkg::REG_FIELDS) begin : g_reg
            assign n_mask[f] = csq_pkg::class_mask(n_roots[4*f +: 4], n_modes[5*f +: 5]);
        end else begin : g_def
            assign n_mask[f] = csq_pkg::class_mask('0, csq_pkg::MODE_MAJOR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roots <= '0;
            r_modes <= '0;
            for (int f = 0; f < N; f++) begin
                r_mask[f] <= csq_pkg::class_mask('0, csq_pkg::MODE_MAJOR);
            end
        end else if (i_cfg_we) begin
            r_roots <= n_roots;
            r_modes <= n_modes;
            for (int f = 0; f < N; f++) begin
                r_mask[f] <= n_mask[f];
            end
        end
    end

    // ------------------------------------------------------ pipeline control
    // a stage loads when it is empty or its content moves on this cycle
    assign w_go[N] = r_vld[N] && w_buf_take;
    for (genvar s = 0; s <= N; s++) begin : g_ctl
        assign w_load[s] = !r_vld[s] || w_go[s];
        if (s < N) begin : g_go
            assign w_go[s] = r_vld[s] && w_load[s+1];
        end
    end

    assign o_stall = !w_load[0];

    // stage 0: register the note and its pitch class
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_load[0]) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[0] && i_valid) begin
            r_pitch[0] <= i_pitch_in;
            r_cls[0]   <= csq_pkg::mod12(i_pitch_in);
            r_rp[0]    <= '0;
            r_rf[0]    <= '0;
        end
    end

    // ---------------------------------------------------------- field stages
    for (genvar s = 1; s <= N; s++) begin : g_field
        logic [11:0]                 w_rot;
        logic [csq_pkg::CLASS_W-1:0] w_dist;
        logic [7:0]                  w_sum;
        logic [4:0]                  w_csum;
        logic                        w_hit;
        logic [csq_pkg::CLASS_W-1:0] w_ncls;
        logic [csq_pkg::PITCH_W-1:0] w_npitch;
        logic [csq_pkg::CLASS_W-1:0] w_ocls;
        logic [csq_pkg::RES_W-1:0]   n_rp;
        logic [N-1:0]                n_rf;

        always_comb begin
            // distance to the next scale class at or above the current one
            w_rot    = csq_pkg::rotr12(r_mask[s-1], r_cls[s-1]);
            w_dist   = csq_pkg::first_set12(w_rot);
            w_sum    = {1'b0, r_pitch[s-1]} + {4'd0, w_dist};
            w_hit    = !w_sum[7];
            w_csum   = {1'b0, r_cls[s-1]} + {1'b0, w_dist};
            w_ncls   = (w_csum >= 5'd12) ? 4'(w_csum - 5'd12) : w_csum[3:0];
            // past the top of the range the pitch goes on unchanged
            w_npitch = w_hit ? w_sum[6:0] : r_pitch[s-1];
            w_ocls   = w_hit ? w_ncls : r_cls[s-1];
            n_rp     = r_rp[s-1];
            n_rp[(s-1)*csq_pkg::PITCH_W +: csq_pkg::PITCH_W] = w_npitch;
            n_rf     = r_rf[s-1];
            n_rf[s-1] = w_hit;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_load[s]) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_load[s] && r_vld[s-1]) begin
                r_pitch[s] <= w_npitch;
                r_cls[s]   <= w_ocls;
                r_rp[s]    <= n_rp;
                r_rf[s]    <= n_rf;
            end
        end
    end

    // ------------------------------------------------------ result serializer
    assign w_out_acc  = r_sv && !i_stall;
    assign w_out_last = (r_idx == csq_pkg::LAST_FIELD);
    // buffer takes the next note when it is empty or once its last result is delivered
    assign w_buf_take = !r_sv || (w_out_acc && w_out_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv  <= 1'b0;
            r_idx <= '0;
        end else if (w_buf_take) begin
            r_sv  <= r_vld[N];
            r_idx <= '0;
        end else if (w_out_acc) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go[N]) begin
            r_bp <= r_rp[N];
            r_bf <= r_rf[N];
        end
    end

    assign o_valid       = r_sv;
    assign o_pitch_out   = r_bp[r_idx*csq_pkg::PITCH_W +: csq_pkg::PITCH_W];
    assign o_field_index = r_idx;
    assign o_found       = r_bf[r_idx];
    assign o_last_result = w_out_last;

    // ------------------------------------------------------------ assertions
`include "assert_macros.svh"

    // serializer index never runs past the final field
    `CSQ_NEVER(a_idx_range, i_clk, i_rst_n, r_sv && (r_idx > csq_pkg::LAST_FIELD), "result index out of range")

    // after a non-final result is taken the next field of the same note follows
    `CSQ_ASSERT(a_field_order, i_clk, i_rst_n, (o_valid && !i_stall && !o_last_result) |=> (o_valid && (r_idx == $past(r_idx) + 3'd1)), "results out of field order")

    // the request side is only held off when the entry stage is occupied
    `CSQ_NEVER(a_stall_empty, i_clk, i_rst_n, o_stall && !r_vld[0], "stall with empty entry stage")

endmodule
